FILE: design/vfhc_pkg.sv
// ----------------------------------------------------------------------------
// vfhc_pkg
// Shared constants, types and functions for the value frequency hash counter.
// ----------------------------------------------------------------------------
package vfhc_pkg;

	localparam int TABLE_LOG    = 11;
	localparam int PROBE_LIMIT  = 10;
	localparam int TABLE_SIZE   = 1 << TABLE_LOG;
	localparam int VALUE_W      = 64;
	localparam int COUNT_W      = 32;
	localparam int EPOCH_W      = 8;
	localparam int USED_W       = TABLE_LOG + 1;
	localparam int PROBE_W      = $clog2(PROBE_LIMIT + 1);
	localparam int SLOT_FIELD_W = 11;
	localparam int USED_FIELD_W = 12;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_FLUSH,
		ST_SWEEP
	} vfhc_state_t;

	// one table entry; an entry whose tag differs from the current epoch is empty
	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [COUNT_W-1:0] count;
		logic [VALUE_W-1:0] value;
	} entry_t;

	function automatic logic [TABLE_LOG-1:0] home_slot(input logic [VALUE_W-1:0] b);
		logic [VALUE_W-1:0] h;
		h = b ^ (b >> 12);
		h = h ^ (h >> 32);
		h = h ^ (h >> (52 - TABLE_LOG));
		return h[TABLE_LOG-1:0];
	endfunction

	function automatic logic is_nan(input logic [VALUE_W-1:0] b);
		return (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
	endfunction

	// double equality: nan never matches, signed zeros match
	function automatic logic double_equal(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		logic both_zero;
		both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
		if (is_nan(a) || is_nan(b)) begin
			return 1'b0;
		end
		return both_zero || (a == b);
	endfunction

endpackage

FILE: design/vfhc_cmd_if.sv
// ----------------------------------------------------------------------------
// vfhc_cmd_if
// Input item channel: count a value or flush the table.
// ----------------------------------------------------------------------------
interface vfhc_cmd_if
	import vfhc_pkg::*;
	();

	logic               valid;
	logic               ready;
	logic               kind;
	logic [VALUE_W-1:0] value_bits;

	modport source (output valid, output kind, output value_bits, input ready);
	modport sink   (input valid, input kind, input value_bits, output ready);

endinterface

FILE: design/vfhc_res_if.sv
// ----------------------------------------------------------------------------
// vfhc_res_if
// Result item channel: slot, count and table occupancy after each item.
// ----------------------------------------------------------------------------
interface vfhc_res_if
	import vfhc_pkg::*;
	();

	logic                    valid;
	logic                    ready;
	logic [SLOT_FIELD_W-1:0] slot;
	logic [COUNT_W-1:0]      new_count;
	logic                    flushed;
	logic [USED_FIELD_W-1:0] used_before_flush;
	logic [USED_FIELD_W-1:0] used_now;

	modport source (output valid, output slot, output new_count, output flushed,
		output used_before_flush, output used_now, input ready);
	modport sink   (input valid, input slot, input new_count, input flushed,
		input used_before_flush, input used_now, output ready);

endinterface

FILE: design/value_frequency_hash_counter.sv
// ----------------------------------------------------------------------------
// value_frequency_hash_counter
// Counts occurrences of double bit patterns in an open-addressing hash table.
// ----------------------------------------------------------------------------
// a count item probes up to 10 slots a stride apart from its home, one table read a cycle;
// results are registered only once the result register is free; an item is taken only while idle
// flushes bump the current epoch, emptying entries with older tags; every 255th flush adds a sweep
// reset: a sweep marks all 2048 entries empty before the first item is taken
// the result register lets the next item in while a finished result waits
module value_frequency_hash_counter
	import vfhc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	vfhc_cmd_if.sink    cmd,
	vfhc_res_if.source  res
);

	localparam logic [TABLE_LOG-1:0] STRIDE = TABLE_LOG'(PROBE_LIMIT + 1);

	vfhc_state_t state_q, state_d;

	logic [TABLE_LOG-1:0] key_q, home_q, sweep_q;
	logic [VALUE_W-1:0]   val_q;
	logic [PROBE_W-1:0]   probe_q;
	logic [EPOCH_W-1:0]   epoch_q, epoch_next;
	logic [USED_W-1:0]    used_q, used_d;
	logic                 pend_q;

	logic                    out_valid_q;
	logic [SLOT_FIELD_W-1:0] out_slot_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic                    out_flushed_q;
	logic [USED_FIELD_W-1:0] out_before_q, out_used_q;

	logic                 ram_we, ram_re;
	logic [TABLE_LOG-1:0] ram_waddr, ram_raddr;
	entry_t               ram_wdata, rd;
	logic [$bits(entry_t)-1:0] ram_rdata;

	logic [TABLE_LOG-1:0] cmd_home;
	logic                 empty, hit, last_probe, epoch_wrap, out_free, accept;
	logic                 emit, key_adv, epoch_adv;
	logic [TABLE_LOG-1:0] r_slot;
	logic [COUNT_W-1:0]   r_count;
	logic                 r_flushed;
	logic [USED_W-1:0]    r_before;

	vfhc_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_SIZE)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd         = entry_t'(ram_rdata);
	assign cmd_home   = home_slot(cmd.value_bits);
	assign empty      = rd.tag != epoch_q;
	assign hit        = !empty && double_equal(rd.value, val_q);
	assign last_probe = probe_q == PROBE_W'(PROBE_LIMIT);
	assign epoch_wrap = epoch_q == '1;
	assign epoch_next = epoch_wrap ? EPOCH_W'(1) : epoch_q + EPOCH_W'(1);
	assign out_free   = !out_valid_q || res.ready;
	assign cmd.ready  = state_q == ST_IDLE;
	assign accept     = cmd.valid && cmd.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = cmd.kind ? ST_FLUSH : ST_PROBE;
				end
			end
			ST_PROBE: begin
				if ((empty || hit) && out_free) begin
					state_d = ST_IDLE;
				end else if (!(empty || hit) && last_probe && out_free) begin
					state_d = epoch_wrap ? ST_SWEEP : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					state_d = epoch_wrap ? ST_SWEEP : ST_IDLE;
				end
			end
			ST_SWEEP: begin
				if (sweep_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath controls and result
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = key_q;
		ram_wdata = '{tag: epoch_q, count: COUNT_W'(1), value: val_q};
		ram_re    = 1'b0;
		ram_raddr = cmd_home;
		emit      = 1'b0;
		key_adv   = 1'b0;
		epoch_adv = 1'b0;
		r_slot    = key_q;
		r_count   = COUNT_W'(1);
		r_flushed = 1'b0;
		r_before  = '0;
		used_d    = used_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_re = cmd.valid && !cmd.kind;
			end
			ST_PROBE: begin
				if (empty || hit) begin
					if (out_free) begin
						emit   = 1'b1;
						ram_we = 1'b1;
						if (empty) begin
							used_d = used_q + USED_W'(1);
						end else begin
							r_count   = (rd.count == '1) ? rd.count : rd.count + COUNT_W'(1);
							ram_wdata = '{tag: epoch_q, count: r_count, value: rd.value};
						end
					end
				end else if (!last_probe) begin
					ram_re    = 1'b1;
					ram_raddr = key_q + STRIDE;
					key_adv   = 1'b1;
				end else if (out_free) begin
					// probes exhausted: flush and restart at the home slot
					emit      = 1'b1;
					epoch_adv = 1'b1;
					r_slot    = home_q;
					r_flushed = 1'b1;
					r_before  = used_q;
					used_d    = USED_W'(1);
					ram_we    = !epoch_wrap;
					ram_waddr = home_q;
					ram_wdata = '{tag: epoch_next, count: COUNT_W'(1), value: val_q};
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					emit      = 1'b1;
					epoch_adv = 1'b1;
					r_slot    = '0;
					r_count   = '0;
					r_flushed = 1'b1;
					r_before  = used_q;
					used_d    = '0;
				end
			end
			ST_SWEEP: begin
				// a pending home entry goes in with the live epoch, all else turns stale
				ram_we    = 1'b1;
				ram_waddr = sweep_q;
				ram_wdata = '{tag: (pend_q && sweep_q == home_q) ? epoch_q : '0,
					count: COUNT_W'(1), value: val_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			epoch_q     <= EPOCH_W'(1);
			used_q      <= '0;
			sweep_q     <= '0;
			pend_q      <= 1'b0;
			probe_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (accept) begin
				probe_q <= PROBE_W'(1);
			end else if (key_adv) begin
				probe_q <= probe_q + PROBE_W'(1);
			end
			if (epoch_adv) begin
				epoch_q <= epoch_next;
				if (epoch_wrap) begin
					sweep_q <= '0;
					pend_q  <= state_q == ST_PROBE;
				end
			end else if (state_q == ST_SWEEP) begin
				sweep_q <= sweep_q + TABLE_LOG'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= cmd_home;
			home_q <= cmd_home;
			val_q  <= cmd.value_bits;
		end else if (key_adv) begin
			key_q <= key_q + STRIDE;
		end
		if (emit) begin
			out_slot_q    <= SLOT_FIELD_W'(r_slot);
			out_count_q   <= r_count;
			out_flushed_q <= r_flushed;
			out_before_q  <= USED_FIELD_W'(r_before);
			out_used_q    <= USED_FIELD_W'(used_d);
		end
	end

	assign res.valid             = out_valid_q;
	assign res.slot              = out_slot_q;
	assign res.new_count         = out_count_q;
	assign res.flushed           = out_flushed_q;
	assign res.used_before_flush = out_before_q;
	assign res.used_now          = out_used_q;

`ifndef ASSERT_OFF
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_SIZE))
		else $error("used count beyond table size");

	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("current epoch equals the stale tag");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && ram_waddr == ram_raddr))
		else $error("read and write of one entry in the same cycle");

	a_exhaust_used: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && r_flushed && state_q == ST_PROBE) |=> used_q == USED_W'(1))
		else $error("used count not one after probe exhaustion");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROBE |-> (probe_q != '0 && probe_q <= PROBE_W'(PROBE_LIMIT)))
		else $error("probe count out of range");
`endif

endmodule

FILE: design/vfhc_ram.sv
// ----------------------------------------------------------------------------
// vfhc_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module vfhc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives count and flush items into the value frequency hash counter with
// random gaps and back-pressure. A scoreboard keeps its own copy of the hash
// table and checks every result field against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
	import vfhc_pkg::*;

	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;
	localparam int   STORM_LEN  = 260;
	localparam int   MAX_PRINTS = 60;

	typedef struct packed {
		logic               kind;
		logic [VALUE_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] slot;
		logic [COUNT_W-1:0]      new_count;
		logic                    flushed;
		logic [USED_FIELD_W-1:0] used_before_flush;
		logic [USED_FIELD_W-1:0] used_now;
	} tally_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// driven through registers so the block sees known levels from time zero
	logic               cmd_valid = 1'b0;
	logic               cmd_kind = KIND_COUNT;
	logic [VALUE_W-1:0] cmd_value = '0;
	logic               res_ready = 1'b0;

	vfhc_cmd_if cmd_ch ();
	vfhc_res_if res_ch ();

	assign cmd_ch.valid      = cmd_valid;
	assign cmd_ch.kind       = cmd_kind;
	assign cmd_ch.value_bits = cmd_value;
	assign res_ch.ready      = res_ready;

	value_frequency_hash_counter u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.res   (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// scoreboard copy of the hash table
	logic [VALUE_W-1:0] slot_vals [TABLE_SIZE];
	logic [COUNT_W-1:0] slot_cnts [TABLE_SIZE];
	logic [USED_W-1:0]  occupied;

	cmd_item_t          pending_items [$];
	tally_t             expected_tallies [$];
	logic [VALUE_W-1:0] seen_values [$];
	logic [TABLE_LOG-1:0] hot_homes [4];

	int unsigned errors;
	int unsigned n_items, n_flush_items, n_full_flushes, n_hits, n_new, peak_used;
	logic        calm;
	int unsigned send_gap, stall_left;

	function automatic logic [TABLE_LOG-1:0] hash_home(input logic [VALUE_W-1:0] b);
		logic [VALUE_W-1:0] h;
		h = b ^ (b >> 12);
		h = h ^ (h >> 32);
		h = h ^ (h >> (52 - TABLE_LOG));
		return h[TABLE_LOG-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] undo_xorshift(input logic [VALUE_W-1:0] y,
			input int s);
		logic [VALUE_W-1:0] x;
		x = y;
		for (int i = 0; i < VALUE_W; i += s) begin
			x = y ^ (x >> s);
		end
		return x;
	endfunction

	// random bit pattern whose home slot is the one asked for
	function automatic logic [VALUE_W-1:0] value_at_home(input logic [TABLE_LOG-1:0] home);
		logic [VALUE_W-1:0] h;
		h = {$urandom, $urandom};
		h[TABLE_LOG-1:0] = home;
		h = undo_xorshift(h, 52 - TABLE_LOG);
		h = undo_xorshift(h, 32);
		return undo_xorshift(h, 12);
	endfunction

	function automatic logic nan_bits(input logic [VALUE_W-1:0] b);
		return (&b[62:52]) && (|b[51:0]);
	endfunction

	function automatic logic doubles_match(input logic [VALUE_W-1:0] a,
			input logic [VALUE_W-1:0] b);
		if (nan_bits(a) || nan_bits(b)) begin
			return 1'b0;
		end
		return (a[62:0] == '0 && b[62:0] == '0) || (a == b);
	endfunction

	function automatic void wipe_table();
		foreach (slot_cnts[i]) begin
			slot_cnts[i] = '0;
		end
		occupied = '0;
	endfunction

	function automatic tally_t tally_item(input logic kind, input logic [VALUE_W-1:0] v);
		tally_t               r;
		logic [TABLE_LOG-1:0] key;
		logic                 placed;
		r = '0;
		placed = 1'b0;
		n_items++;
		if (kind == KIND_FLUSH) begin
			n_flush_items++;
			r.used_before_flush = occupied;
			r.flushed = 1'b1;
			wipe_table();
		end else begin
			key = hash_home(v);
			for (int p = 0; p < PROBE_LIMIT && !placed; p++) begin
				if (slot_cnts[key] == '0) begin
					slot_vals[key] = v;
					slot_cnts[key] = COUNT_W'(1);
					occupied++;
					n_new++;
					placed = 1'b1;
				end else if (doubles_match(slot_vals[key], v)) begin
					if (slot_cnts[key] != '1) begin
						slot_cnts[key]++;
					end
					n_hits++;
					placed = 1'b1;
				end else begin
					key = key + TABLE_LOG'(PROBE_LIMIT + 1);
				end
			end
			if (!placed) begin
				// probe chain full: table cleared, value lands at its home
				n_full_flushes++;
				r.used_before_flush = occupied;
				r.flushed = 1'b1;
				wipe_table();
				key = hash_home(v);
				slot_vals[key] = v;
				slot_cnts[key] = COUNT_W'(1);
				occupied = USED_W'(1);
			end
			r.slot = key;
			r.new_count = slot_cnts[key];
		end
		r.used_now = occupied;
		if (occupied > peak_used) begin
			peak_used = 32'(occupied);
		end
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		errors++;
		if (errors <= MAX_PRINTS) begin
			$display("%0t: mismatch on %s, want %0h got %0h", $time, what, want, got);
		end
	endtask

	task automatic check_result();
		tally_t want;
		if (expected_tallies.size() == 0) begin
			report_mismatch("result with nothing outstanding", '0, VALUE_W'(res_ch.slot));
		end else begin
			want = expected_tallies.pop_front();
			if (res_ch.slot != want.slot)
				report_mismatch("slot", VALUE_W'(want.slot), VALUE_W'(res_ch.slot));
			if (res_ch.new_count != want.new_count)
				report_mismatch("new_count", VALUE_W'(want.new_count),
					VALUE_W'(res_ch.new_count));
			if (res_ch.flushed != want.flushed)
				report_mismatch("flushed", VALUE_W'(want.flushed), VALUE_W'(res_ch.flushed));
			if (res_ch.used_before_flush != want.used_before_flush)
				report_mismatch("used_before_flush", VALUE_W'(want.used_before_flush),
					VALUE_W'(res_ch.used_before_flush));
			if (res_ch.used_now != want.used_now)
				report_mismatch("used_now", VALUE_W'(want.used_now),
					VALUE_W'(res_ch.used_now));
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t it;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (cmd_valid && cmd_ch.ready) begin
				expected_tallies.push_back(tally_item(cmd_kind, cmd_value));
			end
			if (!cmd_valid || cmd_ch.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					cmd_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					it = pending_items.pop_front();
					cmd_kind <= it.kind;
					cmd_value <= it.value;
					cmd_valid <= 1'b1;
					send_gap <= pick_gap();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				check_result();
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				res_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left <= pick_gap();
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	task automatic add_count(input logic [VALUE_W-1:0] v, input logic remember);
		cmd_item_t it;
		it.kind = KIND_COUNT;
		it.value = v;
		pending_items.push_back(it);
		if (remember) begin
			seen_values.push_back(v);
			if (seen_values.size() > 40) begin
				void'(seen_values.pop_front());
			end
		end
	endtask

	task automatic add_flush();
		cmd_item_t it;
		it.kind = KIND_FLUSH;
		it.value = {$urandom, $urandom};
		pending_items.push_back(it);
	endtask

	task automatic add_repeat();
		if (seen_values.size() == 0) begin
			add_count({$urandom, $urandom}, 1'b1);
		end else begin
			add_count(seen_values[$urandom_range(0, seen_values.size() - 1)], 1'b0);
		end
	endtask

	task automatic add_special();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 64'h0000_0000_0000_0000;
			1: v = 64'h8000_0000_0000_0000;
			2: v = 64'h7FF0_0000_0000_0000;
			3: v = 64'hFFF0_0000_0000_0000;
			4: v = {1'b0, 11'h000, 20'h0, $urandom};
			5: v = 64'h7FEF_FFFF_FFFF_FFFF;
			default: v = {$urandom_range(0, 1) == 1, 11'h7FF,
				20'h80000 | 20'($urandom_range(0, 20'hFFFFF)), $urandom};
		endcase
		add_count(v, 1'b1);
	endtask

	task automatic add_random_items(input int unsigned n);
		int unsigned          r;
		logic [VALUE_W-1:0]   v;
		logic [TABLE_LOG-1:0] home;
		int unsigned          added;
		added = 0;
		while (added < n) begin
			r = $urandom_range(0, 99);
			home = hot_homes[$urandom_range(0, 3)];
			if (r < 8) begin
				add_flush();
				added++;
			end else if (r < 38) begin
				add_repeat();
				added++;
			end else if (r < 58) begin
				add_count(value_at_home(home), 1'b1);
				added++;
			end else if (r < 66) begin
				// distinct values sharing a home, enough to fill the probe chain or run out of probes
				repeat ($urandom_range(PROBE_LIMIT, PROBE_LIMIT + 2)) begin
					add_count(value_at_home(home), 1'b1);
					added++;
				end
			end else if (r < 72) begin
				// one nan over and over: each copy takes a new slot
				v = {$urandom_range(0, 1) == 1, 11'h7FF,
					20'h1 | 20'($urandom_range(0, 20'hFFFFF)), $urandom};
				repeat ($urandom_range(PROBE_LIMIT - 1, PROBE_LIMIT + 2)) begin
					add_count(v, 1'b0);
					added++;
				end
			end else if (r < 80) begin
				add_special();
				added++;
			end else begin
				add_count({$urandom, $urandom}, 1'b1);
				added++;
			end
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || cmd_valid) begin
			@(posedge clk);
		end
		while (expected_tallies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		logic [TABLE_LOG-1:0] home;
		errors = 0;
		n_items = 0;
		n_flush_items = 0;
		n_full_flushes = 0;
		n_hits = 0;
		n_new = 0;
		peak_used = 0;
		calm = 1'b0;
		occupied = '0;
		foreach (slot_vals[i]) begin
			slot_vals[i] = '0;
			slot_cnts[i] = '0;
		end
		hot_homes[0] = '0;
		hot_homes[1] = '1;
		hot_homes[2] = TABLE_LOG'(TABLE_SIZE - 8);
		hot_homes[3] = TABLE_LOG'($urandom_range(0, TABLE_SIZE - 1));

		// directed: empty flush, signed zeros, infinities, nans, edges, full chain
		add_flush();
		add_count(64'h0000_0000_0000_0000, 1'b1);
		add_count(64'h8000_0000_0000_0000, 1'b1);
		add_count(64'h0000_0000_0000_0000, 1'b0);
		add_count(64'h7FF0_0000_0000_0000, 1'b1);
		add_count(64'h7FF0_0000_0000_0000, 1'b0);
		add_count(64'hFFF0_0000_0000_0000, 1'b1);
		add_count(64'h7FF8_0000_0000_0000, 1'b0);
		add_count(64'h7FF8_0000_0000_0000, 1'b0);
		add_count(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
		add_count(64'h0000_0000_0000_0001, 1'b1);
		add_count(64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
		add_count(64'h3FF0_0000_0000_0000, 1'b1);
		home = TABLE_LOG'($urandom_range(0, TABLE_SIZE - 1));
		repeat (PROBE_LIMIT + 1) begin
			add_count(value_at_home(home), 1'b1);
		end
		add_flush();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// back to back, no idling on either side
		calm = 1'b1;
		add_random_items(190);
		drain();

		// many flushes in a row to roll the table's internal flush tracking
		calm = 1'b0;
		repeat (STORM_LEN) begin
			add_flush();
			if ($urandom_range(0, 1) == 1) begin
				if ($urandom_range(0, 1) == 1) begin
					add_repeat();
				end else begin
					add_count(value_at_home(hot_homes[$urandom_range(0, 3)]), 1'b1);
				end
			end
		end
		drain();

		add_random_items(190);
		drain();
		repeat (30) @(posedge clk);

		$display("run covered %0d items: %0d flush items, %0d flushes from full probe chains",
			n_items, n_flush_items, n_full_flushes);
		$display("%0d repeat hits, %0d new slots taken, peak occupancy %0d",
			n_hits, n_new, peak_used);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

	initial begin
		#(30_000_000);
		$display("testbench: errors");
		$finish;
	end

endmodule
